// ===== hdl/afsf_pkg.sv =====
`default_nettype none

package afsf_pkg;

	localparam int TRY_LIMIT_DEF = 1200;
	localparam int TRY_W         = 11;
	localparam int POS_W         = 32;
	localparam int ADDR_W        = 4;
	localparam int APB_W         = 32;

	localparam logic [7:0] BYTE_SYNC  = 8'hFF;
	localparam logic [7:0] BYTE_M4A   = 8'h21;
	localparam logic [7:0] BYTE_M4B   = 8'h0A;
	localparam logic [POS_W-1:0] MASK_MONO   = 32'hFFFF_FFFE;
	localparam logic [POS_W-1:0] MASK_STEREO = 32'hFFFF_FFFC;

	localparam logic STAT_FOUND = 1'b0;
	localparam logic STAT_FAIL  = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_EOS   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_PCM  = 3'd0,
		MODE_WMA  = 3'd1,
		MODE_MP4  = 3'd2,
		MODE_MP3  = 3'd3,
		MODE_MP2  = 3'd4,
		MODE_PASS = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_CHANS = 2'd1,
		REG_ALIGN = 2'd2,
		REG_PATT  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SCAN,
		PH_HDR,
		PH_CHKA,
		PH_CHKB,
		PH_M4WAIT,
		PH_M4PAIR,
		PH_DIV
	} phase_t;

	typedef enum logic [2:0] {
		POS_PCM,
		POS_PASS,
		POS_DIV,
		POS_HDR,
		POS_CHK,
		POS_CUR
	} pos_sel_t;

	typedef struct packed {
		logic     start;
		logic     div_start;
		logic     inc1;
		logic     inc2;
		logic     save_hdr;
		logic     save_chk;
		logic     try_inc;
		logic     emit;
		logic     emit_fail;
		pos_sel_t pos_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic       b_sync;
		logic       b_hdr;
		logic       b_m4a;
		logic       b_m4b;
		logic       chk_on;
		logic       chk_match;
		logic       try_hit;
		logic       div_done;
		logic       out_hold;
		logic [2:0] mode;
		logic       ba_zero;
	} dp_sts_t;

	function automatic logic is_header(input logic [7:0] b);
		return b == 8'hFA || b == 8'hFB || b == 8'hFC || b == 8'hFD ||
			b == 8'hF3 || b == 8'hF5;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/afsf_regs.sv =====
`default_nettype none

module afsf_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [afsf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [afsf_pkg::APB_W-1:0]  pwdata,
	output logic      [afsf_pkg::APB_W-1:0]  prdata,
	output logic                            pready,
	output logic      [2:0]                 encoding_mode,
	output logic      [7:0]                 channel_count,
	output logic      [15:0]                block_align,
	output logic      [23:0]                sync_pattern
);
	import afsf_pkg::*;

	logic            wr_en;
	reg_idx_t        idx;
	logic [2:0]      mode_q;
	logic [7:0]      chans_q;
	logic [15:0]     align_q;
	logic [23:0]     patt_q;

	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 3'(MODE_PASS);
			chans_q <= 8'd2;
			align_q <= 16'd0;
			patt_q  <= 24'd0;
		end else if (wr_en) begin
			case (idx)
				REG_MODE:  mode_q  <= pwdata[2:0];
				REG_CHANS: chans_q <= pwdata[7:0];
				REG_ALIGN: align_q <= pwdata[15:0];
				REG_PATT:  patt_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:  prdata = {29'd0, mode_q};
			REG_CHANS: prdata = {24'd0, chans_q};
			REG_ALIGN: prdata = {16'd0, align_q};
			REG_PATT:  prdata = {8'd0, patt_q};
			default:   prdata = '0;
		endcase
	end

	assign encoding_mode = mode_q;
	assign channel_count = chans_q;
	assign block_align   = align_q;
	assign sync_pattern  = patt_q;

endmodule

`default_nettype wire

// ===== hdl/afsf_dp.sv =====
`default_nettype none

module afsf_dp #(
	parameter int TRY_LIMIT = afsf_pkg::TRY_LIMIT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [31:0]                offset,
	input  wire logic [7:0]                 data_byte,
	input  wire logic [2:0]                 encoding_mode,
	input  wire logic [7:0]                 channel_count,
	input  wire logic [15:0]                block_align,
	input  wire logic [23:0]                sync_pattern,
	input  wire afsf_pkg::ctl_cmd_t          ctl,
	output afsf_pkg::dp_sts_t                sts,
	input  wire logic                       out_stall,
	output logic                            out_valid,
	output logic                            status,
	output logic      [afsf_pkg::POS_W-1:0] position
);
	import afsf_pkg::*;

	logic [POS_W-1:0] cur_q;
	logic [7:0]       hdr_q;
	logic [7:0]       chk_q;
	logic [TRY_W-1:0] try_q;
	logic [TRY_W-1:0] try_nx;
	logic [15:0]      rem_q;
	logic [31:0]      dvd_q;
	logic [5:0]       cnt_q;
	logic [16:0]      rem_sh;
	logic [16:0]      rem_sub;
	logic             rem_ge;
	logic             out_valid_q;
	logic             status_q;
	logic [POS_W-1:0] position_q;
	logic [POS_W-1:0] pos_val;

	assign try_nx  = try_q + 1'b1;
	assign rem_sh  = {rem_q, dvd_q[31]};
	assign rem_ge  = rem_sh >= {1'b0, block_align};
	assign rem_sub = rem_sh - {1'b0, block_align};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			hdr_q <= '0;
			chk_q <= '0;
			try_q <= '0;
			cnt_q <= 6'd32;
		end else begin
			if (ctl.start) begin
				cur_q <= offset;
				hdr_q <= '0;
				chk_q <= '0;
				try_q <= '0;
			end else begin
				if (ctl.inc1)
					cur_q <= cur_q + 32'd1;
				else if (ctl.inc2)
					cur_q <= cur_q + 32'd2;
				if (ctl.save_hdr)
					hdr_q <= data_byte;
				if (ctl.save_chk)
					chk_q <= data_byte;
				if (ctl.try_inc)
					try_q <= try_nx;
			end
			if (ctl.div_start)
				cnt_q <= '0;
			else if (!cnt_q[5])
				cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			rem_q <= '0;
			dvd_q <= offset;
		end else if (!cnt_q[5]) begin
			rem_q <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

	always_comb begin
		case (ctl.pos_sel)
			POS_PCM: begin
				if (channel_count == 8'd1)
					pos_val = offset & MASK_MONO;
				else if (channel_count == 8'd2)
					pos_val = offset & MASK_STEREO;
				else
					pos_val = offset;
			end
			POS_PASS: pos_val = offset;
			POS_DIV:  pos_val = cur_q - {16'd0, rem_q};
			POS_HDR:  pos_val = cur_q - 32'd1;
			POS_CHK:  pos_val = cur_q - 32'd3;
			POS_CUR:  pos_val = cur_q;
			default:  pos_val = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			status_q   <= ctl.emit_fail ? STAT_FAIL : STAT_FOUND;
			position_q <= ctl.emit_fail ? '0 : pos_val;
		end
	end

	always_comb begin
		sts.b_sync    = data_byte == BYTE_SYNC;
		sts.b_hdr     = is_header(data_byte);
		sts.b_m4a     = data_byte == BYTE_M4A;
		sts.b_m4b     = data_byte == BYTE_M4B;
		sts.chk_on    = encoding_mode == 3'(MODE_MP2) && sync_pattern[23:16] != 8'd0;
		sts.chk_match = hdr_q == sync_pattern[23:16] && chk_q == sync_pattern[15:8] &&
			data_byte == sync_pattern[7:0];
		sts.try_hit   = try_nx >= TRY_W'(TRY_LIMIT);
		sts.div_done  = cnt_q[5];
		sts.out_hold  = out_valid_q & out_stall;
		sts.mode      = encoding_mode;
		sts.ba_zero   = block_align == 16'd0;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;

`ifndef NO_ASSERTIONS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && ctl.emit_fail |=> out_valid_q && status_q == STAT_FAIL && position_q == '0)
		else $error("failure beat carries a nonzero position");
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |=> !cnt_q[5] && cnt_q == 6'd0)
		else $error("remainder unit did not restart");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[5] && $past(!cnt_q[5]) && block_align != 16'd0 |-> rem_q < block_align)
		else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== hdl/afsf_ctrl.sv =====
`default_nettype none

module afsf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_acc,
	input  wire logic [1:0]        cmd,
	input  wire afsf_pkg::dp_sts_t sts,
	output afsf_pkg::ctl_cmd_t     ctl,
	output logic                   in_stall
);
	import afsf_pkg::*;

	phase_t state_q;
	phase_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= PH_IDLE;
		else
			state_q <= state_nx;
	end

	assign in_stall = (state_q == PH_DIV) | sts.out_hold;

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		ctl.pos_sel = POS_CUR;
		if (state_q == PH_DIV) begin
			if (sts.div_done && !sts.out_hold) begin
				ctl.emit    = 1'b1;
				ctl.pos_sel = POS_DIV;
				state_nx    = PH_IDLE;
			end
		end else if (in_acc) begin
			case (cmd_t'(cmd))
				CMD_START: begin
					ctl.start = 1'b1;
					state_nx  = PH_IDLE;
					case (mode_t'(sts.mode))
						MODE_PCM: begin
							ctl.emit    = 1'b1;
							ctl.pos_sel = POS_PCM;
						end
						MODE_WMA: begin
							if (sts.ba_zero) begin
								ctl.emit    = 1'b1;
								ctl.pos_sel = POS_PASS;
							end else begin
								ctl.div_start = 1'b1;
								state_nx      = PH_DIV;
							end
						end
						MODE_MP4: state_nx = PH_M4WAIT;
						MODE_MP3,
						MODE_MP2: state_nx = PH_SCAN;
						default: begin
							ctl.emit    = 1'b1;
							ctl.pos_sel = POS_PASS;
						end
					endcase
				end
				CMD_DATA: begin
					case (state_q)
						PH_SCAN: begin
							ctl.inc1 = 1'b1;
							if (sts.b_sync)
								state_nx = PH_HDR;
						end
						PH_HDR: begin
							ctl.inc1 = 1'b1;
							if (sts.b_sync)
								state_nx = PH_HDR;
							else if (!sts.b_hdr)
								state_nx = PH_SCAN;
							else if (sts.chk_on) begin
								ctl.save_hdr = 1'b1;
								state_nx     = PH_CHKA;
							end else begin
								ctl.emit    = 1'b1;
								ctl.pos_sel = POS_HDR;
								state_nx    = PH_IDLE;
							end
						end
						PH_CHKA: begin
							ctl.inc1 = 1'b1;
							if (sts.b_sync)
								state_nx = PH_HDR;
							else begin
								ctl.save_chk = 1'b1;
								state_nx     = PH_CHKB;
							end
						end
						PH_CHKB: begin
							ctl.inc1 = 1'b1;
							if (sts.b_sync)
								state_nx = PH_HDR;
							else if (sts.chk_match) begin
								ctl.emit    = 1'b1;
								ctl.pos_sel = POS_CHK;
								state_nx    = PH_IDLE;
							end else
								state_nx = PH_SCAN;
						end
						PH_M4WAIT: begin
							if (sts.b_m4a)
								state_nx = PH_M4PAIR;
							else begin
								ctl.inc1    = 1'b1;
								ctl.try_inc = 1'b1;
								if (sts.try_hit) begin
									ctl.emit      = 1'b1;
									ctl.emit_fail = 1'b1;
									state_nx      = PH_IDLE;
								end
							end
						end
						PH_M4PAIR: begin
							if (sts.b_m4b) begin
								ctl.emit    = 1'b1;
								ctl.pos_sel = POS_CUR;
								state_nx    = PH_IDLE;
							end else begin
								ctl.inc2    = 1'b1;
								ctl.try_inc = 1'b1;
								if (sts.try_hit) begin
									ctl.emit      = 1'b1;
									ctl.emit_fail = 1'b1;
									state_nx      = PH_IDLE;
								end else
									state_nx = PH_M4WAIT;
							end
						end
						default: ;
					endcase
				end
				CMD_EOS: begin
					if (state_q != PH_IDLE) begin
						ctl.emit      = 1'b1;
						ctl.emit_fail = 1'b1;
						state_nx      = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> state_q == PH_IDLE)
		else $error("result beat left a scan running");
	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |=> state_q == PH_DIV)
		else $error("remainder run started outside its phase");
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PH_DIV && !sts.div_done |=> state_q == PH_DIV)
		else $error("left remainder phase before completion");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> !sts.out_hold)
		else $error("result beat overwrites a held beat");
`endif

endmodule

`default_nettype wire

// ===== hdl/audio_frame_sync_finder.sv =====
`default_nettype none

// Audio frame sync finder. A start beat (cmd 0) carries a byte offset and a
// result beat gives the frame start: PCM mode aligns the offset to the
// channel count, passthrough returns it as is, WMA mode rounds it down to a
// multiple of block_align, MP3/MP2 modes scan the data beats (cmd 1) for a
// frame header and report the position of its 0xFF, MP4 mode hunts for the
// pair 0x21 0x0A within TRY_LIMIT tries, and end of stream (cmd 2) during a
// scan reports failure with position 0. A stream byte per cycle is
// sustained while the input is not stalled. A WMA start with a nonzero
// block_align runs the one-bit-per-cycle remainder unit before its result
// beat is loaded. Input stalls during that run and while a result beat is
// held by the output. Registers sit at byte addresses 0, 4, 8 and 12; the
// user must write them only while no scan is running; it is not enforced.
module audio_frame_sync_finder #(
	parameter int TRY_LIMIT = afsf_pkg::TRY_LIMIT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [afsf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [afsf_pkg::APB_W-1:0]  pwdata,
	output logic      [afsf_pkg::APB_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  cmd,
	input  wire logic [31:0]                 offset,
	input  wire logic [7:0]                  data_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             status,
	output logic      [afsf_pkg::POS_W-1:0]  position
);
	import afsf_pkg::*;

	logic        in_acc;
	logic [2:0]  encoding_mode;
	logic [7:0]  channel_count;
	logic [15:0] block_align;
	logic [23:0] sync_pattern;
	ctl_cmd_t    ctl;
	dp_sts_t     sts;

	assign in_acc = in_valid & ~in_stall;

	afsf_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.encoding_mode (encoding_mode),
		.channel_count (channel_count),
		.block_align   (block_align),
		.sync_pattern  (sync_pattern)
	);

	afsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.cmd      (cmd),
		.sts      (sts),
		.ctl      (ctl),
		.in_stall (in_stall)
	);

	afsf_dp #(
		.TRY_LIMIT (TRY_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.offset        (offset),
		.data_byte     (data_byte),
		.encoding_mode (encoding_mode),
		.channel_count (channel_count),
		.block_align   (block_align),
		.sync_pattern  (sync_pattern),
		.ctl           (ctl),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.position      (position)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import afsf_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int ITEM_TARGET = 1775;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic                 st;
		logic [POS_W-1:0]     pos;
	} frame_res_t;

	typedef enum {ROW_BEAT, ROW_REG} row_kind_t;
	typedef enum {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_src_t;

	typedef struct {
		row_kind_t  kind;
		logic [1:0] cmd;
		reg_idx_t   ridx;
		logic [31:0] val;
		logic [7:0] byt;
		exp_src_t   src;
		frame_res_t res;
	} stim_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0]  pwdata = '0;
	logic [APB_W-1:0]  prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd = '0;
	logic [31:0]       offset = '0;
	logic [7:0]        data_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              status;
	logic [POS_W-1:0]  position;

	audio_frame_sync_finder DUT (.*);

	logic [2:0]  cfg_mode = MODE_PASS;
	logic [7:0]  cfg_chans = 8'd2;
	logic [15:0] cfg_align = '0;
	logic [23:0] cfg_patt = '0;
	phase_t      sf_phase = PH_IDLE;
	logic [31:0] sf_base = '0;
	logic [31:0] sf_consumed = '0;
	logic [7:0]  sf_hdr = '0;
	logic [7:0]  sf_chk1 = '0;
	logic [10:0] sf_tries = '0;

	frame_res_t pending_frames [$];
	int mismatches = 0;
	int live_beats = 0;
	int burst_left = 0;
	bit hold_req = 0;

	stim_row_t dir_tab [40] = '{
		'{ROW_BEAT, CMD_START, REG_MODE, 32'hFFFF_FFFF, 8'h00, EXP_GIVEN,
			'{STAT_FOUND, 32'hFFFF_FFFF}},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_EOS, REG_MODE, 32'h0, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_UNUSED, REG_MODE, 32'hFFFF_FFFF, 8'hFF, EXP_NONE, '0},
		'{ROW_REG, CMD_START, REG_MODE, MODE_PCM, 8'h00, EXP_NONE, '0},
		'{ROW_REG, CMD_START, REG_CHANS, 32'd1, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'hFFFF_FFFF, 8'h00, EXP_GIVEN,
			'{STAT_FOUND, 32'hFFFF_FFFE}},
		'{ROW_REG, CMD_START, REG_CHANS, 32'd2, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'hFFFF_FFFF, 8'h00, EXP_GIVEN,
			'{STAT_FOUND, 32'hFFFF_FFFC}},
		'{ROW_REG, CMD_START, REG_CHANS, 32'd255, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'h0000_0003, 8'h00, EXP_GIVEN,
			'{STAT_FOUND, 32'h0000_0003}},
		'{ROW_REG, CMD_START, REG_MODE, MODE_WMA, 8'h00, EXP_NONE, '0},
		'{ROW_REG, CMD_START, REG_ALIGN, 32'hFFFF, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'hFFFF_FFFF, 8'h00, EXP_MODEL, '0},
		'{ROW_REG, CMD_START, REG_ALIGN, 32'h0, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'h0001_2345, 8'h00, EXP_GIVEN,
			'{STAT_FOUND, 32'h0001_2345}},
		'{ROW_REG, CMD_START, REG_MODE, MODE_SPARE7, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'h0, 8'h00, EXP_GIVEN, '{STAT_FOUND, 32'h0}},
		'{ROW_REG, CMD_START, REG_MODE, MODE_MP3, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'hFFFF_FFFE, 8'h00, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, 8'h00, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_SYNC, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_SYNC, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, 8'hFA, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'd10, 8'h00, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_SYNC, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'd20, 8'h00, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_EOS, REG_MODE, 32'h0, 8'h00, EXP_GIVEN, '{STAT_FAIL, 32'h0}},
		'{ROW_REG, CMD_START, REG_MODE, MODE_MP2, 8'h00, EXP_NONE, '0},
		'{ROW_REG, CMD_START, REG_PATT, 32'hF3_80_7F, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'h0, 8'h00, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_SYNC, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, 8'hF3, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, 8'h80, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, 8'h7F, EXP_MODEL, '0},
		'{ROW_REG, CMD_START, REG_MODE, MODE_MP4, 8'h00, EXP_NONE, '0},
		'{ROW_BEAT, CMD_START, REG_MODE, 32'h0, 8'h00, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_M4A, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_M4A, EXP_MODEL, '0},
		'{ROW_BEAT, CMD_DATA, REG_MODE, 32'h0, BYTE_M4B, EXP_MODEL, '0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic locate_frame(input logic [1:0] c, input logic [31:0] off,
		input logic [7:0] b, output bit hit, output frame_res_t r);
		bit tried;
		hit = 0;
		tried = 0;
		r = '0;
		case (c)
			CMD_START: begin
				sf_base = off;
				sf_consumed = '0;
				sf_hdr = '0;
				sf_chk1 = '0;
				sf_tries = '0;
				sf_phase = PH_IDLE;
				case (cfg_mode)
					MODE_PCM: begin
						if (cfg_chans == 8'd1)
							off = off & MASK_MONO;
						else if (cfg_chans == 8'd2)
							off = off & MASK_STEREO;
						hit = 1;
					end
					MODE_WMA: begin
						if (cfg_align != 0)
							off = off - (off % {16'd0, cfg_align});
						hit = 1;
					end
					MODE_MP4: sf_phase = PH_M4WAIT;
					MODE_MP3, MODE_MP2: sf_phase = PH_SCAN;
					default: hit = 1;
				endcase
				r = '{STAT_FOUND, off};
			end
			CMD_DATA: begin
				case (sf_phase)
					PH_SCAN: begin
						sf_consumed++;
						if (b == BYTE_SYNC)
							sf_phase = PH_HDR;
					end
					PH_HDR: begin
						sf_consumed++;
						if (b == BYTE_SYNC) begin
						end else if (!(b inside {8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hF3, 8'hF5})) begin
							sf_phase = PH_SCAN;
						end else if (cfg_mode == MODE_MP2 && cfg_patt[23:16] != 0) begin
							sf_hdr = b;
							sf_phase = PH_CHKA;
						end else begin
							hit = 1;
							r = '{STAT_FOUND, sf_base + sf_consumed - 32'd2};
						end
					end
					PH_CHKA: begin
						sf_consumed++;
						if (b == BYTE_SYNC) begin
							sf_phase = PH_HDR;
						end else begin
							sf_chk1 = b;
							sf_phase = PH_CHKB;
						end
					end
					PH_CHKB: begin
						sf_consumed++;
						if (b == BYTE_SYNC) begin
							sf_phase = PH_HDR;
						end else if (sf_hdr == cfg_patt[23:16] && sf_chk1 == cfg_patt[15:8] &&
							b == cfg_patt[7:0]) begin
							hit = 1;
							r = '{STAT_FOUND, sf_base + sf_consumed - 32'd4};
						end else begin
							sf_phase = PH_SCAN;
						end
					end
					PH_M4WAIT: begin
						if (b == BYTE_M4A) begin
							sf_phase = PH_M4PAIR;
						end else begin
							sf_consumed++;
							tried = 1;
						end
					end
					PH_M4PAIR: begin
						if (b == BYTE_M4B) begin
							hit = 1;
							r = '{STAT_FOUND, sf_base + sf_consumed};
						end else begin
							sf_consumed += 32'd2;
							tried = 1;
						end
					end
					default: ;
				endcase
				if (tried) begin
					sf_tries = sf_tries + 11'd1;
					if (int'(sf_tries) >= TRY_LIMIT_DEF) begin
						hit = 1;
						r = '{STAT_FAIL, '0};
					end else begin
						sf_phase = PH_M4WAIT;
					end
				end
			end
			CMD_EOS: begin
				if (sf_phase != PH_IDLE) begin
					hit = 1;
					r = '{STAT_FAIL, '0};
				end
			end
			default: ;
		endcase
		if (hit)
			sf_phase = PH_IDLE;
	endtask

	task automatic send_beat(input logic [1:0] c, input logic [31:0] off, input logic [7:0] b,
		input exp_src_t src, input frame_res_t given);
		bit hit;
		bit ignored;
		frame_res_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		offset <= off;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		ignored = (c == CMD_UNUSED) || (c != CMD_START && sf_phase == PH_IDLE);
		locate_frame(c, off, b, hit, r);
		if (!ignored)
			live_beats++;
		if (src == EXP_GIVEN)
			pending_frames.push_back(given);
		else if (src == EXP_MODEL && hit)
			pending_frames.push_back(r);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE:  cfg_mode = v[2:0];
			REG_CHANS: cfg_chans = v[7:0];
			REG_ALIGN: cfg_align = v[15:0];
			REG_PATT:  cfg_patt = v[23:0];
		endcase
		@(posedge clk);
	endtask

	// close any open scan, then drain and let the block settle
	task automatic quiesce();
		if (sf_phase != PH_IDLE)
			send_beat(CMD_EOS, $urandom, 8'($urandom_range(0, 255)), EXP_MODEL, '0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] hdr_pick();
		case ($urandom_range(0, 5))
			0: return 8'hFA;
			1: return 8'hFB;
			2: return 8'hFC;
			3: return 8'hFD;
			4: return 8'hF3;
			default: return 8'hF5;
		endcase
	endfunction

	function automatic logic [31:0] rand_off();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic scan_seq(input bit mp2);
		send_beat(CMD_START, rand_off(), rand_byte(), EXP_MODEL, '0);
		repeat ($urandom_range(0, 10))
			send_beat(CMD_DATA, $urandom, rand_byte(), EXP_MODEL, '0);
		if ($urandom_range(0, 4) != 0) begin
			send_beat(CMD_DATA, $urandom, BYTE_SYNC, EXP_MODEL, '0);
			if ($urandom_range(0, 3) == 0)
				send_beat(CMD_DATA, $urandom, BYTE_SYNC, EXP_MODEL, '0);
			send_beat(CMD_DATA, $urandom, hdr_pick(), EXP_MODEL, '0);
			if (mp2) begin
				send_beat(CMD_DATA, $urandom,
					($urandom_range(0, 4) != 0) ? cfg_patt[15:8] : rand_byte(), EXP_MODEL, '0);
				send_beat(CMD_DATA, $urandom,
					($urandom_range(0, 4) != 0) ? cfg_patt[7:0] : rand_byte(), EXP_MODEL, '0);
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_beat(CMD_EOS, $urandom, rand_byte(), EXP_MODEL, '0);
	endtask

	task automatic mp4_seq(input bit run_out);
		logic [7:0] b;
		send_beat(CMD_START, rand_off(), rand_byte(), EXP_MODEL, '0);
		if (run_out) begin
			repeat (TRY_LIMIT_DEF) begin
				b = rand_byte();
				if (b == BYTE_M4A)
					b = 8'h00;
				send_beat(CMD_DATA, $urandom, b, EXP_MODEL, '0);
			end
		end else begin
			repeat ($urandom_range(0, 12))
				send_beat(CMD_DATA, $urandom, rand_byte(), EXP_MODEL, '0);
			send_beat(CMD_DATA, $urandom, BYTE_M4A, EXP_MODEL, '0);
			send_beat(CMD_DATA, $urandom,
				($urandom_range(0, 4) != 0) ? BYTE_M4B : rand_byte(), EXP_MODEL, '0);
			if ($urandom_range(0, 3) == 0)
				send_beat(CMD_EOS, $urandom, rand_byte(), EXP_MODEL, '0);
		end
	endtask

	task automatic run_phase(input int idx);
		logic [2:0]  m;
		logic [7:0]  ch;
		logic [15:0] al;
		logic [23:0] pt;
		int nseq;
		if (idx == 0)
			m = MODE_PCM;
		else if (idx == 2)
			m = MODE_MP4;
		else begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: m = MODE_MP3;
				6, 7, 8, 9, 10, 11: m = MODE_MP2;
				12, 13, 14: m = MODE_MP4;
				15: m = MODE_PCM;
				16: m = MODE_WMA;
				17: m = MODE_PASS;
				18: m = MODE_SPARE6;
				default: m = MODE_SPARE7;
			endcase
		end
		case ($urandom_range(0, 5))
			0: ch = 8'd0;
			1: ch = 8'd1;
			2: ch = 8'd2;
			3: ch = 8'd255;
			default: ch = rand_byte();
		endcase
		case ($urandom_range(0, 5))
			0: al = 16'd0;
			1: al = 16'd1;
			2: al = 16'hFFFF;
			3: al = 16'($urandom_range(2, 16));
			default: al = 16'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: pt = 24'h0;
			1: pt = 24'hFF_FFFF;
			2: pt = {8'h00, 16'($urandom)};
			default: pt = {hdr_pick(), 16'($urandom)};
		endcase
		quiesce();
		reg_write(REG_MODE, {29'd0, m});
		reg_write(REG_CHANS, {24'd0, ch});
		reg_write(REG_ALIGN, {16'd0, al});
		reg_write(REG_PATT, {8'd0, pt});
		nseq = (idx == 0) ? 40 : $urandom_range(4, 24);
		if (idx == 0)
			hold_req = 1;
		for (int s = 0; s < nseq; s++) begin
			case (m)
				MODE_MP3: scan_seq(0);
				MODE_MP2: scan_seq(1);
				MODE_MP4: mp4_seq(idx == 2 && s == 0);
				default: begin
					send_beat(CMD_START, rand_off(), rand_byte(), EXP_MODEL, '0);
					if ($urandom_range(0, 5) == 0)
						send_beat(2'($urandom_range(1, 3)), $urandom, rand_byte(), EXP_MODEL, '0);
				end
			endcase
		end
	endtask

	initial begin
		int hold_left;
		int seg_left;
		int style;
		hold_left = 0;
		seg_left = 0;
		style = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					style = $urandom_range(0, 2);
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 2) != 0);
				endcase
			end
		end
	end

	initial begin
		frame_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_frames.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d position %h",
						$time, status, position);
					mismatches++;
				end else begin
					want = pending_frames.pop_front();
					if (status !== want.st) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.st, status);
						mismatches++;
					end
					if (position !== want.pos) begin
						$display("%0t: position mismatch, expected %h, got %h",
							$time, want.pos, position);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG) begin
				$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int idx;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_REG) begin
				quiesce();
				reg_write(dir_tab[i].ridx, dir_tab[i].val);
			end else begin
				send_beat(dir_tab[i].cmd, dir_tab[i].val, dir_tab[i].byt, dir_tab[i].src,
					dir_tab[i].res);
			end
		end
		idx = 0;
		while (live_beats < ITEM_TARGET) begin
			run_phase(idx);
			idx++;
		end
		quiesce();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
